FILE: rtl/core/sid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sid_pkg;

    typedef enum logic [1:0] {
        OP_AMBIENT = 2'd0,
        OP_ARM     = 2'd1,
        OP_DETECT  = 2'd2,
        OP_FINISH  = 2'd3
    } t_op;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BASE_RISE   = 3'd0,
        CFG_MAX_LAG_MS  = 3'd1,
        CFG_MIN_RISE    = 3'd2,
        CFG_NOISE_GAIN  = 3'd3,
        CFG_NOISE_FLOOR = 3'd4,
        CFG_HYSTERESIS  = 3'd5,
        CFG_GUARD_MS    = 3'd6
    } t_cfg_index;

    localparam int OUT_DATA_BITS = 96;

    localparam logic [33:0] TRIG_MAX   = 34'h0_7FFF_FFFF;
    localparam logic [15:0] SPREAD_MAX = 16'hFFFF;
    localparam logic [14:0] AMB_MAX    = 15'h7FFF;

    typedef struct packed {
        logic [31:0] trigger;
        logic [31:0] rearm;
        logic [15:0] spread;
    } t_arm_levels;

endpackage

`default_nettype wire

FILE: rtl/core/sid_arm_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module sid_arm_calc #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] i_amb_peak,
    input  logic signed [SAMPLE_BITS-1:0] i_amb_low,
    input  logic signed [SAMPLE_BITS-1:0] i_amb_high,
    input  logic [15:0]                   i_base_rise,
    input  logic [7:0]                    i_noise_gain,
    input  logic [15:0]                   i_noise_floor,
    input  logic [15:0]                   i_hysteresis,
    output sid_pkg::t_arm_levels          o_levels
);
    import sid_pkg::*;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > 17) ? DIFF_BITS : 17;

    logic signed [DIFF_BITS-1:0] spread_raw;
    logic signed [CMP_BITS-1:0]  spread_ext;
    logic [15:0]                 spread;
    logic [23:0]                 noise_scaled;
    logic [24:0]                 noise_rise;
    logic [24:0]                 rise;
    logic [33:0]                 trig_sum;
    logic [31:0]                 trigger;
    logic [32:0]                 rearm_full;

    always_comb begin
        spread_raw = DIFF_BITS'(i_amb_high) - DIFF_BITS'(i_amb_low);
        spread_ext = CMP_BITS'(spread_raw);
        // negative means no ambient sample came in
        if (spread_raw[DIFF_BITS-1]) begin
            spread = '0;
        end else if ($unsigned(spread_ext) > CMP_BITS'(SPREAD_MAX)) begin
            spread = SPREAD_MAX;
        end else begin
            spread = spread_ext[15:0];
        end

        noise_scaled = 24'(spread) * 24'(i_noise_gain);
        noise_rise   = 25'(noise_scaled) + 25'(i_noise_floor);
        rise         = (noise_rise > 25'(i_base_rise)) ? noise_rise : 25'(i_base_rise);

        // ambient peak is never negative, so only the upper bound can clip
        trig_sum = 34'($unsigned(i_amb_peak)) + 34'(rise);
        trigger  = (trig_sum > TRIG_MAX) ? TRIG_MAX[31:0] : trig_sum[31:0];

        rearm_full = {1'b0, trigger} - 33'(i_hysteresis);

        o_levels.trigger = trigger;
        o_levels.rearm   = rearm_full[31:0];
        o_levels.spread  = spread;
    end

endmodule

`default_nettype wire

FILE: rtl/core/strike_impact_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// one item per clock, one input register and one result register in line
// a finish transfer passes the input register and then the result register before it shows on m_axis
// ambient, arm and detect items give no result and never wait in the input register
// a finish item waits in the input register only while an earlier result is unread
// synchronous active-low reset clears the configuration, the measurement state and both valids

module strike_impact_detector #(
    parameter int  SAMPLE_BITS  = 16,
    localparam int IN_DATA_BITS = ((SAMPLE_BITS + 16 + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sid_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sid_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample, elapsed_ms, zero fill
    input  logic [IN_DATA_BITS-1:0]            s_axis_tdata,
    // op
    input  logic [1:0]                         s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit, lag_ms, peak_rise, ambient_level, trigger_level, noise_spread
    output logic [sid_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import sid_pkg::*;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > 17) ? DIFF_BITS : 17;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic [15:0] r_base_rise;
    logic [15:0] r_max_lag_ms;
    logic [15:0] r_min_rise;
    logic [7:0]  r_noise_gain;
    logic [15:0] r_noise_floor;
    logic [15:0] r_hysteresis;
    logic [15:0] r_guard_ms;

    // input register
    logic                          r_in_valid;
    t_op                           r_in_op;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic [15:0]                   r_in_elapsed;

    // measurement state
    logic signed [SAMPLE_BITS-1:0] r_amb_peak;
    logic signed [SAMPLE_BITS-1:0] r_amb_low;
    logic signed [SAMPLE_BITS-1:0] r_amb_high;
    logic signed [31:0]            r_trigger;
    logic signed [31:0]            r_rearm;
    logic [15:0]                   r_spread;
    logic signed [SAMPLE_BITS-1:0] r_window_peak;
    logic                          r_crossed_below;
    logic                          r_hit_flag;
    logic [15:0]                   r_hit_lag;

    // result register
    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;

    logic                        advance;
    t_arm_levels                 levels;
    logic signed [32:0]          sample_ext;
    logic                        below_rearm;
    logic                        arm_below;
    logic                        at_trigger;
    logic                        in_window;
    logic                        after_guard;
    logic                        crossed_now;
    logic signed [DIFF_BITS-1:0] rise_raw;
    logic signed [CMP_BITS-1:0]  rise_ext;
    logic [15:0]                 fin_rise;
    logic signed [CMP_BITS-1:0]  amb_ext;
    logic [14:0]                 fin_amb;
    logic                        fin_hit;
    logic [15:0]                 fin_lag;

    sid_arm_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_arm_calc (
        .i_amb_peak    (r_amb_peak),
        .i_amb_low     (r_amb_low),
        .i_amb_high    (r_amb_high),
        .i_base_rise   (r_base_rise),
        .i_noise_gain  (r_noise_gain),
        .i_noise_floor (r_noise_floor),
        .i_hysteresis  (r_hysteresis),
        .o_levels      (levels)
    );

    // a finish may only move on when the result register is free or being read
    assign advance = r_in_valid && ((r_in_op != OP_FINISH) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rise   <= '0;
            r_max_lag_ms  <= '0;
            r_min_rise    <= '0;
            r_noise_gain  <= '0;
            r_noise_floor <= '0;
            r_hysteresis  <= '0;
            r_guard_ms    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_RISE:   r_base_rise   <= i_cfg_data;
                CFG_MAX_LAG_MS:  r_max_lag_ms  <= i_cfg_data;
                CFG_MIN_RISE:    r_min_rise    <= i_cfg_data;
                CFG_NOISE_GAIN:  r_noise_gain  <= i_cfg_data[7:0];
                CFG_NOISE_FLOOR: r_noise_floor <= i_cfg_data;
                CFG_HYSTERESIS:  r_hysteresis  <= i_cfg_data;
                CFG_GUARD_MS:    r_guard_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op      <= t_op'(s_axis_tuser);
            r_in_sample  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_elapsed <= s_axis_tdata[SAMPLE_BITS+15:SAMPLE_BITS];
        end
    end

    always_comb begin
        sample_ext  = 33'(r_in_sample);
        below_rearm = sample_ext <= 33'(r_rearm);
        arm_below   = sample_ext <= 33'($signed(levels.rearm));
        at_trigger  = sample_ext >= 33'(r_trigger);
        in_window   = r_in_elapsed <= r_max_lag_ms;
        after_guard = r_in_elapsed >= r_guard_ms;
        crossed_now = r_crossed_below || below_rearm;

        rise_raw = DIFF_BITS'(r_window_peak) - DIFF_BITS'(r_amb_peak);
        rise_ext = CMP_BITS'(rise_raw);
        if (rise_raw[DIFF_BITS-1]) begin
            fin_rise = '0;
        end else if ($unsigned(rise_ext) > CMP_BITS'(SPREAD_MAX)) begin
            fin_rise = SPREAD_MAX;
        end else begin
            fin_rise = rise_ext[15:0];
        end

        amb_ext = CMP_BITS'(r_amb_peak);
        fin_amb = ($unsigned(amb_ext) > CMP_BITS'(AMB_MAX)) ? AMB_MAX : amb_ext[14:0];

        fin_hit = r_hit_flag && (fin_rise >= r_min_rise);
        fin_lag = fin_hit ? r_hit_lag : r_max_lag_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb_peak      <= '0;
            r_amb_low       <= SAMPLE_MAX;
            r_amb_high      <= SAMPLE_MIN;
            r_trigger       <= '0;
            r_rearm         <= '0;
            r_spread        <= '0;
            r_window_peak   <= '0;
            r_crossed_below <= 1'b0;
            r_hit_flag      <= 1'b0;
            r_hit_lag       <= '0;
        end else if (advance) begin
            case (r_in_op)
                OP_AMBIENT: begin
                    if (r_in_sample > r_amb_peak) r_amb_peak <= r_in_sample;
                    if (r_in_sample < r_amb_low)  r_amb_low  <= r_in_sample;
                    if (r_in_sample > r_amb_high) r_amb_high <= r_in_sample;
                end
                OP_ARM: begin
                    r_trigger       <= $signed(levels.trigger);
                    r_rearm         <= $signed(levels.rearm);
                    r_spread        <= levels.spread;
                    r_window_peak   <= r_amb_peak;
                    r_crossed_below <= arm_below;
                    r_hit_flag      <= 1'b0;
                    r_hit_lag       <= '0;
                end
                OP_DETECT: begin
                    if (in_window && (r_in_sample > r_window_peak)) begin
                        r_window_peak <= r_in_sample;
                    end
                    r_crossed_below <= crossed_now;
                    // only the first qualifying crossing is kept
                    if (!r_hit_flag && after_guard && in_window && crossed_now && at_trigger) begin
                        r_hit_flag <= 1'b1;
                        r_hit_lag  <= r_in_elapsed;
                    end
                end
                OP_FINISH: begin
                    r_amb_peak      <= '0;
                    r_amb_low       <= SAMPLE_MAX;
                    r_amb_high      <= SAMPLE_MIN;
                    r_trigger       <= '0;
                    r_rearm         <= '0;
                    r_spread        <= '0;
                    r_window_peak   <= '0;
                    r_crossed_below <= 1'b0;
                    r_hit_flag      <= 1'b0;
                    r_hit_lag       <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && (r_in_op == OP_FINISH)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && (r_in_op == OP_FINISH)) begin
            r_out_data <= {r_spread, r_trigger, fin_amb, fin_rise, fin_lag, fin_hit};
        end
    end

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op == OP_FINISH)) |=> m_axis_tvalid)
        else $error("finish transfer did not load the result register");

    a_finish_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_op == OP_FINISH)) |=>
            (!r_hit_flag && !r_crossed_below && (r_trigger == '0) && (r_window_peak == '0)))
        else $error("measurement state not cleared after finish");

    a_levels_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_trigger[31] && (r_rearm <= r_trigger))
        else $error("rearm level above trigger or trigger negative");

endmodule

`default_nettype wire
